FILE: rtl/ipkt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipkt_pkg
// Shared types and constants of the ID pair key table: port words, status
// codes, default sizes and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package ipkt_pkg;

    localparam int ENTRIES_DEF      = 256;
    localparam int ID_BITS_DEF      = 64;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int FIELD_BITS  = 64;
    localparam int STATUS_BITS = 2;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [FIELD_BITS-1:0] client_id;
        logic [FIELD_BITS-1:0] server_id;
        logic [FIELD_BITS-1:0] payload_in;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FIELD_BITS-1:0]  payload_out;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic clr;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/ipkt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipkt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ipkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/ipkt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipkt_dp
// Datapath: captured word, entry RAM, scan index, first-match and
// first-empty trackers, and the output register.
// ----------------------------------------------------------------------------
module ipkt_dp #(
    parameter int ENTRIES      = ipkt_pkg::ENTRIES_DEF,
    parameter int ID_BITS      = ipkt_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = ipkt_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ipkt_pkg::t_dp_cmd  i_cmd,
    output ipkt_pkg::t_dp_sts       o_sts,
    input  wire ipkt_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ipkt_pkg::t_out_word     o_out_word
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ROW_W = 2 * ID_BITS + PAYLOAD_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic                    r_cmd;
    logic [ID_BITS-1:0]      r_cid;
    logic [ID_BITS-1:0]      r_sid;
    logic [PAYLOAD_BITS-1:0] r_pay;

    logic [IDX_W-1:0]        r_idx;
    logic                    r_chk_v;
    logic [IDX_W-1:0]        r_chk_idx;

    logic                    r_m_found;
    logic [IDX_W-1:0]        r_m_idx;
    logic [PAYLOAD_BITS-1:0] r_m_pay;
    logic                    r_e_found;
    logic [IDX_W-1:0]        r_e_idx;

    logic                    r_out_v;
    ipkt_pkg::t_out_word     r_out;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [ROW_W-1:0]        wdata;
    logic [ROW_W-1:0]        rdata;
    logic [ID_BITS-1:0]      rd_cid;
    logic [ID_BITS-1:0]      rd_sid;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    hit;
    logic                    empty;
    logic                    wr_ok;

    assign rd_cid = rdata[ROW_W-1 -: ID_BITS];
    assign rd_sid = rdata[PAYLOAD_BITS +: ID_BITS];
    assign rd_pay = rdata[PAYLOAD_BITS-1:0];
    assign hit    = r_chk_v && (rd_cid == r_cid) && (rd_sid == r_sid);
    assign empty  = r_chk_v && (rdata == '0);
    assign wr_ok  = r_m_found || r_e_found;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        if (i_cmd.clr) begin
            we = 1'b1;
        end else if (i_cmd.commit && r_cmd == ipkt_pkg::CMD_WRITE && wr_ok) begin
            we    = 1'b1;
            waddr = r_m_found ? r_m_idx : r_e_idx;
            wdata = {r_cid, r_sid, r_pay};
        end
    end

    ipkt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_word.cmd;
            r_cid <= i_in_word.client_id[ID_BITS-1:0];
            r_sid <= i_in_word.server_id[ID_BITS-1:0];
            r_pay <= i_in_word.payload_in[PAYLOAD_BITS-1:0];
        end
        if (hit && !r_m_found) begin
            r_m_idx <= r_chk_idx;
            r_m_pay <= rd_pay;
        end
        if (empty && !r_e_found) begin
            r_e_idx <= r_chk_idx;
        end
        r_chk_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_chk_v   <= 1'b0;
            r_m_found <= 1'b0;
            r_e_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx     <= '0;
            r_chk_v   <= 1'b0;
            r_m_found <= 1'b0;
            r_e_found <= 1'b0;
        end else begin
            if (i_cmd.clr || i_cmd.step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            r_chk_v <= i_cmd.step;
            if (hit) begin
                r_m_found <= 1'b1;
            end
            if (empty) begin
                r_e_found <= 1'b1;
            end
        end
    end

    // hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_cmd == ipkt_pkg::CMD_READ) begin
                r_out.status      <= r_m_found ? ipkt_pkg::ST_OK : ipkt_pkg::ST_NOT_FOUND;
                r_out.payload_out <= r_m_found ? ipkt_pkg::FIELD_BITS'(r_m_pay) : '0;
            end else begin
                r_out.status      <= wr_ok ? ipkt_pkg::ST_OK : ipkt_pkg::ST_FULL;
                r_out.payload_out <= '0;
            end
        end
    end

    assign o_sts.last     = (r_idx == LAST_IDX);
    assign o_sts.out_free = !r_out_v || i_out_ready;
    assign o_out_valid    = r_out_v;
    assign o_out_word     = r_out;

endmodule

`default_nettype wire

FILE: rtl/ipkt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipkt_ctrl
// Controller: clearing pass after reset, then accept, scan, flush and commit
// for each input word.
// ----------------------------------------------------------------------------
module ipkt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ipkt_pkg::t_dp_sts i_sts,
    output ipkt_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/id_pair_key_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id_pair_key_table
// Associative table keyed by a client/server ID pair with write-or-update
// and lookup.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes every entry before
// it raises o_in_ready. Each word then goes from acceptance to result in an
// accept step, a scan that reads one entry per cycle from the single read
// port of the entry RAM, a flush step for the last registered read, and a
// commit step that writes the entry and loads the output register once that
// register is free. The scan records the lowest-index matching ID pair and
// the lowest-index all-zero entry; a write updates the match, else fills the
// empty entry, else reports table full. The next word is accepted while a
// result still waits in the output register.
// ----------------------------------------------------------------------------
module id_pair_key_table #(
    parameter int ENTRIES      = ipkt_pkg::ENTRIES_DEF,
    parameter int ID_BITS      = ipkt_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = ipkt_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ipkt_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ipkt_pkg::t_out_word     o_out_word
);

    ipkt_pkg::t_dp_cmd cmd;
    ipkt_pkg::t_dp_sts sts;

    ipkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ipkt_dp #(
        .ENTRIES      (ENTRIES),
        .ID_BITS      (ID_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID pair key table testbench
// Sends write and read words to id_pair_key_table and tracks its own copy of
// the entry store. It predicts the status and payload of each word and
// compares every result in order. The run covers directed edge cases, a
// random mix over a small pool of ID pairs, filling the table past full,
// freeing an entry through the zero pair, and a final run with no idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ENTRIES      = ipkt_pkg::ENTRIES_DEF;
    localparam int ID_BITS      = ipkt_pkg::ID_BITS_DEF;
    localparam int PAYLOAD_BITS = ipkt_pkg::PAYLOAD_BITS_DEF;
    localparam logic [63:0] ID_MASK  = (ID_BITS >= 64) ? '1 : ((64'd1 << ID_BITS) - 1);
    localparam logic [63:0] PAY_MASK =
        (PAYLOAD_BITS >= 64) ? '1 : ((64'd1 << PAYLOAD_BITS) - 1);
    localparam int POOL_SIZE    = 48;
    localparam int TOTAL_WORDS  = 1150;
    localparam int MAX_PRINTS   = 40;

    logic                 i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                out_ready = 1'b0;
    ipkt_pkg::t_in_word  in_word = '0;
    logic                in_ready;
    logic                out_valid;
    ipkt_pkg::t_out_word out_word;

    logic [63:0] cli_mem [ENTRIES];
    logic [63:0] srv_mem [ENTRIES];
    logic [63:0] pay_mem [ENTRIES];
    logic [63:0] pool_cid [POOL_SIZE];
    logic [63:0] pool_sid [POOL_SIZE];

    ipkt_pkg::t_out_word pending_results [$];
    ipkt_pkg::t_out_word want_word;
    logic [ipkt_pkg::STATUS_BITS-1:0] last_status;

    int  items_sent = 0;
    int  err_count = 0;
    int  results_seen = 0;
    int  n_writes = 0;
    int  n_reads = 0;
    int  n_full = 0;
    int  n_miss = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;

    id_pair_key_table #(
        .ENTRIES(ENTRIES),
        .ID_BITS(ID_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_word(in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word(out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[id_pair_key_table] ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] shaped_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return ~(64'd1 << $urandom_range(0, 63));
            default: return rand64();
        endcase
    endfunction

    function automatic ipkt_pkg::t_in_word make_word(logic cmd, logic [63:0] cid,
                                                     logic [63:0] sid, logic [63:0] pay);
        ipkt_pkg::t_in_word w;
        w.cmd = cmd;
        w.client_id = cid;
        w.server_id = sid;
        w.payload_in = pay;
        return w;
    endfunction

    function automatic ipkt_pkg::t_out_word lookup_or_store(ipkt_pkg::t_in_word w);
        ipkt_pkg::t_out_word r;
        logic [63:0] cid;
        logic [63:0] sid;
        logic [63:0] pay;
        int slot;
        cid = w.client_id & ID_MASK;
        sid = w.server_id & ID_MASK;
        pay = w.payload_in & PAY_MASK;
        r.status = ipkt_pkg::ST_OK;
        r.payload_out = '0;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && cli_mem[i] == cid && srv_mem[i] == sid) slot = i;
        end
        if (w.cmd == ipkt_pkg::CMD_READ) begin
            n_reads++;
            if (slot >= 0) begin
                r.payload_out = pay_mem[slot];
            end else begin
                r.status = ipkt_pkg::ST_NOT_FOUND;
                n_miss++;
            end
        end else begin
            n_writes++;
            if (slot < 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && cli_mem[i] == '0 && srv_mem[i] == '0 && pay_mem[i] == '0)
                        slot = i;
                end
            end
            if (slot >= 0) begin
                cli_mem[slot] = cid;
                srv_mem[slot] = sid;
                pay_mem[slot] = pay;
            end else begin
                r.status = ipkt_pkg::ST_FULL;
                n_full++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_PRINTS)
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // hold valid until the word is taken, then log its expected result
    task automatic send_word(input ipkt_pkg::t_in_word w);
        ipkt_pkg::t_out_word r;
        if (items_sent % 32 == 0) tx_gaps = $urandom_range(0, 1);
        if (idle_on && tx_gaps && $urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (!in_ready);
        r = lookup_or_store(w);
        last_status = r.status;
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic random_step();
        int idx;
        logic [63:0] pay;
        idx = $urandom_range(0, POOL_SIZE - 1);
        pay = ($urandom_range(0, 7) == 0) ? '0 : shaped_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                send_word(make_word(ipkt_pkg::CMD_WRITE, pool_cid[idx], pool_sid[idx], pay));
            4, 5, 6, 7:
                send_word(make_word(ipkt_pkg::CMD_READ, pool_cid[idx], pool_sid[idx],
                                    rand64()));
            8: send_word(make_word(ipkt_pkg::CMD_WRITE, rand64(), rand64(), pay));
            default:
                send_word(make_word(ipkt_pkg::CMD_READ, shaped_value(), shaped_value(),
                                    rand64()));
        endcase
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        logic [63:0] cid;
        logic [63:0] sid;
        ones = '1;
        cid = 64'd1 << $urandom_range(0, 63);
        sid = ~(64'd1 << $urandom_range(0, 63));
        send_word(make_word(ipkt_pkg::CMD_READ, '0, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_READ, ones, ones, ones));
        send_word(make_word(ipkt_pkg::CMD_WRITE, ones, ones, ones));
        send_word(make_word(ipkt_pkg::CMD_READ, ones, ones, '0));
        send_word(make_word(ipkt_pkg::CMD_WRITE, '0, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_READ, '0, '0, ones));
        send_word(make_word(ipkt_pkg::CMD_WRITE, '0, ones, 64'h8000_0000_0000_0000));
        send_word(make_word(ipkt_pkg::CMD_WRITE, ones, '0, 64'd1));
        send_word(make_word(ipkt_pkg::CMD_WRITE, ones, ones, 64'h5555_5555_5555_5555));
        send_word(make_word(ipkt_pkg::CMD_READ, ones, ones, ones));
        send_word(make_word(ipkt_pkg::CMD_WRITE, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA));
        send_word(make_word(ipkt_pkg::CMD_READ, '0, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_WRITE, '0, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_WRITE, rand64(), rand64(), rand64()));
        send_word(make_word(ipkt_pkg::CMD_READ, '0, ones, '0));
        send_word(make_word(ipkt_pkg::CMD_READ, ones, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_WRITE, cid, sid, ones));
        send_word(make_word(ipkt_pkg::CMD_READ, cid, sid, '0));
        send_word(make_word(ipkt_pkg::CMD_READ, sid, cid, '0));
        drain_results();
    endtask

    task automatic test_random_mix();
        repeat (450) random_step();
        drain_results();
    endtask

    // fill every free entry, then free the zero-pair entry and reuse it
    task automatic test_fill_and_reuse();
        int full_hits;
        int guard;
        full_hits = 0;
        guard = 0;
        send_word(make_word(ipkt_pkg::CMD_WRITE, '0, '0, rand64() | 64'd1));
        while (full_hits < 8 && guard < 2 * ENTRIES) begin
            send_word(make_word(ipkt_pkg::CMD_WRITE, rand64() | 64'd1, rand64(), rand64()));
            if (last_status == ipkt_pkg::ST_FULL) full_hits++;
            if ($urandom_range(0, 3) == 0) random_step();
            guard++;
        end
        send_word(make_word(ipkt_pkg::CMD_READ, '0, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_WRITE, '0, '0, '0));
        send_word(make_word(ipkt_pkg::CMD_WRITE, rand64() | 64'd1, rand64(), rand64()));
        send_word(make_word(ipkt_pkg::CMD_WRITE, rand64() | 64'd1, rand64(), rand64()));
        send_word(make_word(ipkt_pkg::CMD_READ, '0, '0, '0));
        drain_results();
    endtask

    task automatic test_no_idle_tail();
        idle_on = 1'b0;
        while (items_sent < TOTAL_WORDS) random_step();
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            cli_mem[i] = '0;
            srv_mem[i] = '0;
            pay_mem[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_cid[i] = (i == 0) ? '0 : shaped_value();
            pool_sid[i] = (i == 0) ? '0 : shaped_value();
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_fill_and_reuse();
        test_no_idle_tail();
        repeat (2 * ENTRIES + 20) @(posedge i_clk);
        $display("covered %0d words: %0d writes, %0d reads", items_sent, n_writes, n_reads);
        $display("table full %0d times, lookup misses %0d, results checked %0d",
                 n_full, n_miss, results_seen);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("[id_pair_key_table] OK");
        end else begin
            $display("[id_pair_key_table] ERROR");
        end
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 499) == 0) rx_stalls = ~rx_stalls;
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && rx_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", out_word.payload_out, '0);
            end else begin
                want_word = pending_results.pop_front();
                if (out_word.status !== want_word.status)
                    report_mismatch("status", 64'(out_word.status), 64'(want_word.status));
                if (out_word.payload_out !== want_word.payload_out)
                    report_mismatch("payload", out_word.payload_out, want_word.payload_out);
            end
        end
    end

endmodule
